[rtl/vic_pkg.sv]
// Shared types and constants for the vectored interrupt controller.
// Register offsets, access codes and default sizes used by the interfaces and the RTL.
// No dependencies.
package vic_pkg;

    // Default configuration of the controller.
    localparam int NUM_SOURCES_DEF = 32;
    localparam int NUM_VECTORS_DEF = 16;

    // Field widths of the bus and result items.
    localparam int ADDR_W     = 12;
    localparam int DATA_W     = 32;
    localparam int LINES_W    = 32;
    localparam int BASE_W     = 10;
    localparam int NUMBER_W   = 11;
    localparam int CTL_W      = 6;
    localparam int CTL_SRC_W  = 5;
    localparam int CTL_EN_BIT = 5;

    // Access kinds carried by each item; the fourth code is treated as idle.
    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    // Register byte offsets.
    localparam logic [ADDR_W-1:0] ADDR_IRQ_STATUS = 12'h000;
    localparam logic [ADDR_W-1:0] ADDR_FIQ_STATUS = 12'h004;
    localparam logic [ADDR_W-1:0] ADDR_RAW_STATUS = 12'h008;
    localparam logic [ADDR_W-1:0] ADDR_FIQ_SELECT = 12'h00c;
    localparam logic [ADDR_W-1:0] ADDR_EN_SET     = 12'h010;
    localparam logic [ADDR_W-1:0] ADDR_EN_CLR     = 12'h014;
    localparam logic [ADDR_W-1:0] ADDR_SOFT_SET   = 12'h018;
    localparam logic [ADDR_W-1:0] ADDR_SOFT_CLR   = 12'h01c;
    localparam logic [ADDR_W-1:0] ADDR_VECT_ADDR  = 12'h030;
    localparam logic [ADDR_W-1:0] ADDR_DEF_VECT   = 12'h034;
    localparam logic [ADDR_W-1:0] ADDR_VEC_ADDR   = 12'h100;
    localparam logic [ADDR_W-1:0] ADDR_VEC_CTL    = 12'h200;

endpackage

[rtl/vic_ifs.sv]
// Handshake interfaces of the vectored interrupt controller: bus items, result items
// and the configuration write channel. Depends on vic_pkg.
interface vic_in_if
    import vic_pkg::*;
();
    logic               valid;
    logic               ready;
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  wdata;
    logic [LINES_W-1:0] source_lines;

    modport source (output valid, output op, output addr, output wdata,
                    output source_lines, input ready);
    modport sink   (input valid, input op, input addr, input wdata,
                    input source_lines, output ready);
endinterface

interface vic_out_if
    import vic_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   rdata;
    logic                irq_out;
    logic                fiq_out;
    logic                pending_valid;
    logic [NUMBER_W-1:0] pending_number;

    modport source (output valid, output rdata, output irq_out, output fiq_out,
                    output pending_valid, output pending_number, input ready);
    modport sink   (input valid, input rdata, input irq_out, input fiq_out,
                    input pending_valid, input pending_number, output ready);
endinterface

interface vic_cfg_if
    import vic_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] irq_number_base;

    modport source (output valid, output irq_number_base, input ready);
    modport sink   (input valid, input irq_number_base, output ready);
endinterface

[rtl/vectored_interrupt_controller_unit.sv]
// Top level of the vectored interrupt controller: register file, status logic,
// vector priority search and the two-stage item pipeline. Depends on vic_pkg, vic_ifs.
//
//  channel  direction  carries
//  bus      in         op, addr, wdata, source_lines
//  result   out        rdata, irq_out, fiq_out, pending_valid, pending_number
//  cfg      in         irq_number_base (write only, always ready)
//
// An item is registered in the input stage on acceptance and its result in the result stage,
// and one item is taken every cycle while the result is not stalled.
// The rate is set by the single pass of decode, vector search and status encode.
// A stalled result holds its register; the input register keeps taking an item
// while the result waits, and stalls only when both stages are full.
// Reset clears the state registers, vector slots, in-service marks and valid flags.
module vectored_interrupt_controller_unit
    import vic_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF,
    parameter int NUM_VECTORS = NUM_VECTORS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    vic_in_if.sink    bus,
    vic_out_if.source result,
    vic_cfg_if.sink   cfg
);

    localparam int SRC_IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int VIDX_W    = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
    localparam logic [ADDR_W-1:0] VEC_ADDR_END = ADDR_W'(ADDR_VEC_ADDR + 4 * NUM_VECTORS);
    localparam logic [ADDR_W-1:0] VEC_CTL_END  = ADDR_W'(ADDR_VEC_CTL + 4 * NUM_VECTORS);

    // Architectural state.
    logic [NUM_SOURCES-1:0] enable_reg, enable_next;
    logic [NUM_SOURCES-1:0] fiq_sel_reg, fiq_sel_next;
    logic [NUM_SOURCES-1:0] soft_reg, soft_next;
    logic [DATA_W-1:0]      vec_addr_reg [NUM_VECTORS];
    logic [DATA_W-1:0]      vec_addr_next [NUM_VECTORS];
    logic [CTL_W-1:0]       vec_ctl_reg [NUM_VECTORS];
    logic [CTL_W-1:0]       vec_ctl_next [NUM_VECTORS];
    logic [DATA_W-1:0]      dflt_addr_reg, dflt_addr_next;
    logic [NUM_VECTORS:0]   marks_reg, marks_next;
    logic [BASE_W-1:0]      base_reg;

    // Input stage.
    logic                   s1_valid_reg;
    op_t                    s1_op_reg;
    logic [ADDR_W-1:0]      s1_addr_reg;
    logic [DATA_W-1:0]      s1_wdata_reg;
    logic [NUM_SOURCES-1:0] s1_lines_reg;

    // Result stage.
    logic                   out_valid_reg;
    logic [DATA_W-1:0]      out_rdata_reg, out_rdata_next;
    logic                   out_irq_reg, out_irq_next;
    logic                   out_fiq_reg, out_fiq_next;
    logic [NUMBER_W-1:0]    out_number_reg, out_number_next;

    logic advance;
    logic fire;

    // Pipeline flow control.
    assign advance   = !out_valid_reg || result.ready;
    assign fire      = s1_valid_reg && advance;
    assign bus.ready = !s1_valid_reg || advance;
    assign cfg.ready = 1'b1;

    // Status and vector search on the state before the access.
    logic [NUM_SOURCES-1:0] raw_pre, irq_pre, fiq_pre;
    logic [LINES_W-1:0]     irq_pre_ext;
    logic [NUM_VECTORS-1:0] slot_hit;
    logic                   win_found;
    logic [VIDX_W-1:0]      win_idx;
    logic                   blocked;

    always_comb
    begin
        raw_pre     = s1_lines_reg | soft_reg;
        irq_pre     = raw_pre & enable_reg & ~fiq_sel_reg;
        fiq_pre     = raw_pre & enable_reg & fiq_sel_reg;
        irq_pre_ext = LINES_W'(irq_pre);
        // A slot is eligible only if it has higher priority (lower index) than every slot in service.
        blocked = 1'b0;
        for (int i = 0; i < NUM_VECTORS; i++)
        begin
            blocked     = blocked | marks_reg[i];
            slot_hit[i] = !blocked && vec_ctl_reg[i][CTL_EN_BIT]
                          && irq_pre_ext[vec_ctl_reg[i][CTL_SRC_W-1:0]];
        end
        win_found = |slot_hit;
        win_idx   = '0;
        for (int i = NUM_VECTORS - 1; i >= 0; i--)
        begin
            if (slot_hit[i])
            begin
                win_idx = VIDX_W'(i);
            end
        end
    end

    // Address decode of the access in the input stage.
    logic              is_read;
    logic              is_write;
    logic              in_vec_addr;
    logic              in_vec_ctl;
    logic [VIDX_W-1:0] reg_vidx;
    logic [VIDX_W-1:0] vaddr_idx;
    logic [DATA_W-1:0] vaddr_rd;

    // Both slot windows start on a multiple of 32 words, so the low word bits index.
    assign is_read     = (s1_op_reg == OP_READ);
    assign is_write    = (s1_op_reg == OP_WRITE);
    assign in_vec_addr = (s1_addr_reg >= ADDR_VEC_ADDR) && (s1_addr_reg < VEC_ADDR_END);
    assign in_vec_ctl  = (s1_addr_reg >= ADDR_VEC_CTL) && (s1_addr_reg < VEC_CTL_END);
    assign reg_vidx    = s1_addr_reg[VIDX_W+1:2];
    assign vaddr_idx   = (s1_addr_reg == ADDR_VECT_ADDR) ? win_idx : reg_vidx;
    assign vaddr_rd    = vec_addr_reg[vaddr_idx];

    // Read data mux; the vector address read returns the winner or the default.
    always_comb
    begin
        out_rdata_next = '0;
        if (is_read)
        begin
            unique case (s1_addr_reg)
                ADDR_IRQ_STATUS: out_rdata_next = DATA_W'(irq_pre);
                ADDR_FIQ_STATUS: out_rdata_next = DATA_W'(fiq_pre);
                ADDR_RAW_STATUS: out_rdata_next = DATA_W'(raw_pre);
                ADDR_FIQ_SELECT: out_rdata_next = DATA_W'(fiq_sel_reg);
                ADDR_EN_SET:     out_rdata_next = DATA_W'(enable_reg);
                ADDR_SOFT_SET:   out_rdata_next = DATA_W'(soft_reg);
                ADDR_VECT_ADDR:  out_rdata_next = win_found ? vaddr_rd : dflt_addr_reg;
                ADDR_DEF_VECT:   out_rdata_next = dflt_addr_reg;
                default:
                begin
                    if (in_vec_addr)
                    begin
                        out_rdata_next = vaddr_rd;
                    end
                    else if (in_vec_ctl)
                    begin
                        out_rdata_next = DATA_W'(vec_ctl_reg[reg_vidx]);
                    end
                end
            endcase
        end
    end

    // State update for the access in the input stage.
    always_comb
    begin
        enable_next    = enable_reg;
        fiq_sel_next   = fiq_sel_reg;
        soft_next      = soft_reg;
        vec_addr_next  = vec_addr_reg;
        vec_ctl_next   = vec_ctl_reg;
        dflt_addr_next = dflt_addr_reg;
        marks_next     = marks_reg;
        if (fire && is_read && (s1_addr_reg == ADDR_VECT_ADDR))
        begin
            // Acknowledge: mark the winner, or the default when an IRQ is pending and nothing is in service.
            if (win_found)
            begin
                marks_next[win_idx] = 1'b1;
            end
            else if ((|irq_pre) && !(|marks_reg))
            begin
                marks_next[NUM_VECTORS] = 1'b1;
            end
        end
        else if (fire && is_write)
        begin
            unique case (s1_addr_reg)
                ADDR_FIQ_SELECT: fiq_sel_next   = s1_wdata_reg[NUM_SOURCES-1:0];
                ADDR_EN_SET:     enable_next    = enable_reg | s1_wdata_reg[NUM_SOURCES-1:0];
                ADDR_EN_CLR:     enable_next    = enable_reg & ~s1_wdata_reg[NUM_SOURCES-1:0];
                ADDR_SOFT_SET:   soft_next      = soft_reg | s1_wdata_reg[NUM_SOURCES-1:0];
                ADDR_SOFT_CLR:   soft_next      = soft_reg & ~s1_wdata_reg[NUM_SOURCES-1:0];
                ADDR_VECT_ADDR:  marks_next     = marks_reg & (marks_reg - 1'b1);
                ADDR_DEF_VECT:   dflt_addr_next = s1_wdata_reg;
                default:
                begin
                    if (in_vec_addr)
                    begin
                        vec_addr_next[reg_vidx] = s1_wdata_reg;
                    end
                    else if (in_vec_ctl)
                    begin
                        vec_ctl_next[reg_vidx] = s1_wdata_reg[CTL_W-1:0];
                    end
                end
            endcase
        end
    end

    // Status after the access and the lowest pending IRQ number.
    logic [NUM_SOURCES-1:0] irq_post, fiq_post;
    logic [SRC_IDX_W-1:0]   low_idx;

    always_comb
    begin
        irq_post = (s1_lines_reg | soft_next) & enable_next & ~fiq_sel_next;
        fiq_post = (s1_lines_reg | soft_next) & enable_next & fiq_sel_next;
        low_idx  = '0;
        for (int i = NUM_SOURCES - 1; i >= 0; i--)
        begin
            if (irq_post[i])
            begin
                low_idx = SRC_IDX_W'(i);
            end
        end
        out_irq_next    = |irq_post;
        out_fiq_next    = |fiq_post;
        out_number_next = out_irq_next
                          ? (NUMBER_W'(base_reg) + NUMBER_W'(low_idx)) : '0;
    end

    // Architectural state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= '0;
            fiq_sel_reg   <= '0;
            soft_reg      <= '0;
            dflt_addr_reg <= '0;
            marks_reg     <= '0;
            base_reg      <= '0;
            for (int i = 0; i < NUM_VECTORS; i++)
            begin
                vec_addr_reg[i] <= '0;
                vec_ctl_reg[i]  <= '0;
            end
        end
        else
        begin
            enable_reg    <= enable_next;
            fiq_sel_reg   <= fiq_sel_next;
            soft_reg      <= soft_next;
            dflt_addr_reg <= dflt_addr_next;
            marks_reg     <= marks_next;
            vec_addr_reg  <= vec_addr_next;
            vec_ctl_reg   <= vec_ctl_next;
            if (cfg.valid)
            begin
                base_reg <= cfg.irq_number_base;
            end
        end
    end

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (bus.ready)
        begin
            s1_valid_reg <= bus.valid;
        end
    end

    // Input stage payload; the byte lanes of the address are dropped.
    always_ff @(posedge clk)
    begin
        if (bus.valid && bus.ready)
        begin
            s1_op_reg    <= bus.op;
            s1_addr_reg  <= {bus.addr[ADDR_W-1:2], 2'b00};
            s1_wdata_reg <= bus.wdata;
            s1_lines_reg <= bus.source_lines[NUM_SOURCES-1:0];
        end
    end

    // Result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_rdata_reg  <= out_rdata_next;
            out_irq_reg    <= out_irq_next;
            out_fiq_reg    <= out_fiq_next;
            out_number_reg <= out_number_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.rdata          = out_rdata_reg;
    assign result.irq_out        = out_irq_reg;
    assign result.fiq_out        = out_fiq_reg;
    assign result.pending_valid  = out_irq_reg;
    assign result.pending_number = out_number_reg;

endmodule

[rtl/vic_checker.sv]
// Port-level checks on the vectored interrupt controller's result channel.
// Attached to the top level by the bind at the end of this file. Depends on vic_pkg.
module vic_checker
    import vic_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input logic [DATA_W-1:0]   res_rdata,
    input logic                res_irq,
    input logic                res_pending_valid,
    input logic [NUMBER_W-1:0] res_pending_number
);

    // No result is offered while reset is held.
    assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result offered during reset");

    // A stalled result keeps its read data.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_rdata))
        else $error("stalled result changed");

    // The pending flag follows the IRQ line of the same item.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_pending_valid == res_irq))
        else $error("pending flag differs from irq line");

    // Without a pending IRQ the reported number is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_pending_valid |-> (res_pending_number == '0))
        else $error("pending number set without pending irq");

endmodule

bind vectored_interrupt_controller_unit vic_checker u_vic_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (result.valid),
    .res_ready          (result.ready),
    .res_rdata          (result.rdata),
    .res_irq            (result.irq_out),
    .res_pending_valid  (result.pending_valid),
    .res_pending_number (result.pending_number)
);
